/* hdl/zpbp_pkg.sv */
package zpbp_pkg;

  // record buffer sizing
  localparam int MAX_SAMPLES = 64;
  localparam int ADDR_W      = $clog2(MAX_SAMPLES);
  localparam int LEN_W       = $clog2(MAX_SAMPLES + 1);

  // number formats
  localparam int SAMPLE_W  = 16;
  localparam int DATA_W    = 32;
  localparam int FRAC_W    = 16;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int TERM_SHIFT = 2;
  localparam int ACC_SHIFT  = 28;

  // pass sequencing
  localparam int NUM_PASSES = 4;
  localparam int PASS_W     = $clog2(NUM_PASSES + 1);

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_LP_GAIN = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_LP_FB1  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_LP_FB2  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_HP_GAIN = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_HP_FB1  = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_HP_FB2  = CFG_IDX_W'(5);

  // multiplier coefficient select
  localparam logic [1:0] CS_K  = 2'd0;
  localparam logic [1:0] CS_F1 = 2'd1;
  localparam logic [1:0] CS_F2 = 2'd2;

  // multiplier data select
  localparam logic [2:0] DS_X0 = 3'd0;
  localparam logic [2:0] DS_X1 = 3'd1;
  localparam logic [2:0] DS_X2 = 3'd2;
  localparam logic [2:0] DS_Y1 = 3'd3;
  localparam logic [2:0] DS_Y2 = 3'd4;

  // accumulator operations
  localparam logic [2:0] AO_NONE = 3'd0;
  localparam logic [2:0] AO_LOAD = 3'd1;
  localparam logic [2:0] AO_ADD  = 3'd2;
  localparam logic [2:0] AO_MID  = 3'd3;
  localparam logic [2:0] AO_SUB  = 3'd4;

  // jump conditions
  localparam logic [1:0] JC_NONE = 2'd0;
  localparam logic [1:0] JC_SAMP = 2'd1;
  localparam logic [1:0] JC_PASS = 2'd2;
  localparam logic [1:0] JC_OUT  = 2'd3;

  // microprogram step addresses
  localparam int UPC_W = 4;
  localparam logic [UPC_W-1:0] U_PASS_INIT = UPC_W'(0);
  localparam logic [UPC_W-1:0] U_READ      = UPC_W'(1);
  localparam logic [UPC_W-1:0] U_MAC_K0    = UPC_W'(2);
  localparam logic [UPC_W-1:0] U_MAC_K1    = UPC_W'(3);
  localparam logic [UPC_W-1:0] U_MAC_K2    = UPC_W'(4);
  localparam logic [UPC_W-1:0] U_MAC_F1    = UPC_W'(5);
  localparam logic [UPC_W-1:0] U_MAC_F2    = UPC_W'(6);
  localparam logic [UPC_W-1:0] U_ACC_LAST  = UPC_W'(7);
  localparam logic [UPC_W-1:0] U_COMMIT    = UPC_W'(8);
  localparam logic [UPC_W-1:0] U_NEXT_PASS = UPC_W'(9);
  localparam logic [UPC_W-1:0] U_OUT_INIT  = UPC_W'(10);
  localparam logic [UPC_W-1:0] U_OUT_READ  = UPC_W'(11);
  localparam logic [UPC_W-1:0] U_DRAIN     = UPC_W'(12);
  localparam logic [UPC_W-1:0] U_DONE      = UPC_W'(13);

  // payload items
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       record_end;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       out_last;
  } out_item_t;

  // coefficient registers
  typedef struct packed {
    logic signed [DATA_W-1:0] lp_gain;
    logic signed [DATA_W-1:0] lp_fb1;
    logic signed [DATA_W-1:0] lp_fb2;
    logic signed [DATA_W-1:0] hp_gain;
    logic signed [DATA_W-1:0] hp_fb1;
    logic signed [DATA_W-1:0] hp_fb2;
  } coef_t;

  // control word of one microprogram step
  typedef struct packed {
    logic             hist_clr;
    logic             pos_init;
    logic             rd_en;
    logic             mul_en;
    logic [1:0]       coef_sel;
    logic [2:0]       data_sel;
    logic [2:0]       acc_op;
    logic             commit;
    logic             pass_inc;
    logic             out_rd;
    logic             done;
    logic [1:0]       jcond;
    logic [UPC_W-1:0] jtarget;
  } ctrl_t;

  // datapath status for conditional jumps
  typedef struct packed {
    logic more_samp;
    logic more_pass;
    logic more_out;
  } stat_t;

  // microprogram rom
  function automatic ctrl_t ucode_rom(input logic [UPC_W-1:0] upc);
    ctrl_t w;
    w = '0;
    unique case (upc)
      U_PASS_INIT: begin
        w.hist_clr = 1'b1;
        w.pos_init = 1'b1;
      end
      U_READ: begin
        w.rd_en = 1'b1;
      end
      U_MAC_K0: begin
        w.mul_en   = 1'b1;
        w.coef_sel = CS_K;
        w.data_sel = DS_X0;
      end
      U_MAC_K1: begin
        w.mul_en   = 1'b1;
        w.coef_sel = CS_K;
        w.data_sel = DS_X1;
        w.acc_op   = AO_LOAD;
      end
      U_MAC_K2: begin
        w.mul_en   = 1'b1;
        w.coef_sel = CS_K;
        w.data_sel = DS_X2;
        w.acc_op   = AO_MID;
      end
      U_MAC_F1: begin
        w.mul_en   = 1'b1;
        w.coef_sel = CS_F1;
        w.data_sel = DS_Y1;
        w.acc_op   = AO_ADD;
      end
      U_MAC_F2: begin
        w.mul_en   = 1'b1;
        w.coef_sel = CS_F2;
        w.data_sel = DS_Y2;
        w.acc_op   = AO_SUB;
      end
      U_ACC_LAST: begin
        w.acc_op = AO_SUB;
      end
      U_COMMIT: begin
        w.commit  = 1'b1;
        w.jcond   = JC_SAMP;
        w.jtarget = U_MAC_K0;
      end
      U_NEXT_PASS: begin
        w.pass_inc = 1'b1;
        w.jcond    = JC_PASS;
        w.jtarget  = U_PASS_INIT;
      end
      U_OUT_INIT: begin
        w.pos_init = 1'b1;
      end
      U_OUT_READ: begin
        w.out_rd  = 1'b1;
        w.jcond   = JC_OUT;
        w.jtarget = U_OUT_READ;
      end
      U_DRAIN: begin
        w.acc_op = AO_NONE;
      end
      U_DONE: begin
        w.done = 1'b1;
      end
      default: begin
        w.done = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

/* hdl/zero_phase_biquad_bandpass_top.sv */
// channel   ports                        handshake
// input     start, busy, in_data         item taken when start and not busy
// result    out_valid, out_data          one-cycle strobe, no back-pressure
// config    cfg_we, cfg_index, cfg_data  written when cfg_we is high
//
// loading takes one item a cycle while not busy; the item flagged record_end
// launches the run. for a record of n samples, each of the four passes then runs
// seven microprogram steps per sample, five of them on the one shared 32x32
// multiplier, plus three steps of overhead, and readout streams one item a cycle.
// results come back to back in one burst; the last strobe falls in the final busy cycle.
// reset clears coefficients, record length and sequencer; the buffers need no clearing.
module zero_phase_biquad_bandpass_top import zpbp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_item_t             in_data,
  output logic                 out_valid,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data
);

  coef_t                    coef_r;
  logic [LEN_W-1:0]         len_r;
  logic                     accept;
  logic                     load_we;
  logic                     launch;
  logic signed [DATA_W-1:0] load_data;
  ctrl_t                    ctrl;
  stat_t                    stat;
  logic signed [DATA_W-1:0] out_word;

  logic                     emit_r;
  logic                     emit_last_r;
  logic                     out_valid_r;
  out_item_t                out_data_r;
  logic signed [DATA_W:0]   out_rnd;
  logic [DATA_W-FRAC_W:0]   out_scaled;
  logic signed [SAMPLE_W-1:0] out_sat;

  // coefficient registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LP_GAIN: coef_r.lp_gain <= cfg_data;
        REG_LP_FB1:  coef_r.lp_fb1  <= cfg_data;
        REG_LP_FB2:  coef_r.lp_fb2  <= cfg_data;
        REG_HP_GAIN: coef_r.hp_gain <= cfg_data;
        REG_HP_FB1:  coef_r.hp_fb1  <= cfg_data;
        REG_HP_FB2:  coef_r.hp_fb2  <= cfg_data;
        default: ;
      endcase
    end
  end

  // record loading, samples past the buffer are dropped
  assign accept    = start && !busy;
  assign load_we   = accept && (len_r < LEN_W'(MAX_SAMPLES));
  assign launch    = accept && in_data.record_end;
  assign load_data = {in_data.sample_in, {FRAC_W{1'b0}}};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else if (ctrl.done) begin
      len_r <= '0;
    end else if (load_we) begin
      len_r <= len_r + LEN_W'(1);
    end
  end

  zpbp_useq u_useq (
    .clk    (clk),
    .rst_n  (rst_n),
    .launch (launch),
    .stat   (stat),
    .ctrl   (ctrl),
    .busy   (busy)
  );

  zpbp_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .coef      (coef_r),
    .rec_len   (len_r),
    .load_we   (load_we),
    .load_addr (len_r[ADDR_W-1:0]),
    .load_data (load_data),
    .stat      (stat),
    .out_word  (out_word)
  );

  // readout: round q16.16 to integer and saturate to 16 bits
  assign out_rnd    = {out_word[DATA_W-1], out_word} + (DATA_W+1)'(1 << (FRAC_W - 1));
  assign out_scaled = out_rnd[DATA_W:FRAC_W];

  always_comb begin
    if (out_scaled[DATA_W-FRAC_W] == out_scaled[SAMPLE_W-1]) begin
      out_sat = out_scaled[SAMPLE_W-1:0];
    end else begin
      out_sat = out_scaled[DATA_W-FRAC_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
                                          : {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  end

  // read data arrives in the cycle after the read, result registered after that
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_r      <= 1'b0;
      emit_last_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      emit_r      <= ctrl.out_rd;
      emit_last_r <= ctrl.out_rd && !stat.more_out;
      out_valid_r <= emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_r) begin
      out_data_r.sample_out <= out_sat;
      out_data_r.out_last   <= emit_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* hdl/zpbp_ram.sv */
module zpbp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // single write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read, held when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hdl/zpbp_useq.sv */
module zpbp_useq import zpbp_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  launch,
  input  stat_t stat,
  output ctrl_t ctrl,
  output logic  busy
);

  logic             run_r;
  logic             run_nxt;
  logic [UPC_W-1:0] upc_r;
  logic [UPC_W-1:0] upc_nxt;
  ctrl_t            rom_w;
  logic             take;

  // control word lookup
  assign rom_w = ucode_rom(upc_r);
  assign ctrl  = run_r ? rom_w : '0;

  // jump condition
  always_comb begin
    case (rom_w.jcond)
      JC_SAMP: take = stat.more_samp;
      JC_PASS: take = stat.more_pass;
      JC_OUT:  take = stat.more_out;
      default: take = 1'b0;
    endcase
  end

  // step counter
  always_comb begin
    run_nxt = run_r;
    upc_nxt = upc_r;
    if (launch) begin
      run_nxt = 1'b1;
      upc_nxt = U_PASS_INIT;
    end else if (run_r) begin
      upc_nxt = take ? rom_w.jtarget : upc_r + UPC_W'(1);
      if (rom_w.done) begin
        run_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      upc_r <= U_PASS_INIT;
    end else begin
      run_r <= run_nxt;
      upc_r <= upc_nxt;
    end
  end

  assign busy = run_r;

endmodule

/* hdl/zpbp_dpath.sv */
module zpbp_dpath import zpbp_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ctrl_t                    ctrl,
  input  coef_t                    coef,
  input  logic [LEN_W-1:0]         rec_len,
  input  logic                     load_we,
  input  logic [ADDR_W-1:0]        load_addr,
  input  logic signed [DATA_W-1:0] load_data,
  output stat_t                    stat,
  output logic signed [DATA_W-1:0] out_word
);

  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) <<< (ACC_SHIFT - 1);
  localparam logic signed [DATA_W-1:0] S32_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] S32_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  logic [PASS_W-1:0]        pass_r;
  logic [ADDR_W-1:0]        pos_r;
  logic [ADDR_W-1:0]        pos_step;
  logic [ADDR_W-1:0]        last_pos;
  logic                     backward;
  logic                     highpass;

  logic signed [DATA_W-1:0] rd_a;
  logic signed [DATA_W-1:0] rd_b;
  logic signed [DATA_W-1:0] x0;
  logic signed [DATA_W-1:0] x1_r;
  logic signed [DATA_W-1:0] x2_r;
  logic signed [DATA_W-1:0] y1_r;
  logic signed [DATA_W-1:0] y2_r;
  logic signed [DATA_W-1:0] y_new;

  logic signed [DATA_W-1:0] k_c;
  logic signed [DATA_W-1:0] f1_c;
  logic signed [DATA_W-1:0] f2_c;
  logic signed [DATA_W-1:0] mul_a;
  logic signed [DATA_W-1:0] mul_b;
  logic signed [PROD_W-1:0] prod_c;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] term;
  logic signed [PROD_W-1:0] term2;
  logic signed [PROD_W-1:0] acc_r;
  logic signed [PROD_W-1:0] acc_nxt;
  logic signed [PROD_W-1:0] rnd;
  logic [PROD_W-DATA_W:0]   rnd_hi;

  logic                     we_a;
  logic                     we_b;
  logic                     re_a;
  logic                     re_b;
  logic [ADDR_W-1:0]        waddr_a;
  logic [DATA_W-1:0]        wdata_a;
  logic [ADDR_W-1:0]        raddr;

  // pass decode: odd passes run backward, upper passes are high-pass
  assign backward = pass_r[0];
  assign highpass = pass_r[1];
  assign last_pos = ADDR_W'(rec_len - LEN_W'(1));
  assign pos_step = backward ? pos_r - ADDR_W'(1) : pos_r + ADDR_W'(1);

  // jump status
  assign stat.more_samp = backward ? (pos_r != '0) : (pos_r != last_pos);
  assign stat.more_pass = (pass_r != PASS_W'(NUM_PASSES - 1));
  assign stat.more_out  = (pos_r != last_pos);

  // pass and position counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pass_r <= '0;
      pos_r  <= '0;
    end else begin
      if (ctrl.done) begin
        pass_r <= '0;
      end else if (ctrl.pass_inc) begin
        pass_r <= pass_r + PASS_W'(1);
      end
      if (ctrl.pos_init) begin
        pos_r <= backward ? last_pos : '0;
      end else if (ctrl.commit || ctrl.out_rd) begin
        pos_r <= pos_step;
      end
    end
  end

  // buffer ports: passes ping-pong between the two buffers
  assign raddr   = ctrl.commit ? pos_step : pos_r;
  assign re_a    = ((ctrl.rd_en || ctrl.commit) && !backward) || ctrl.out_rd;
  assign re_b    = (ctrl.rd_en || ctrl.commit) && backward;
  assign we_a    = load_we || (ctrl.commit && backward);
  assign we_b    = ctrl.commit && !backward;
  assign waddr_a = load_we ? load_addr : pos_r;
  assign wdata_a = load_we ? load_data : y_new;

  zpbp_ram #(.WIDTH(DATA_W), .DEPTH(MAX_SAMPLES)) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr_a),
    .wdata (wdata_a),
    .re    (re_a),
    .raddr (raddr),
    .rdata (rd_a)
  );

  zpbp_ram #(.WIDTH(DATA_W), .DEPTH(MAX_SAMPLES)) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (pos_r),
    .wdata (y_new),
    .re    (re_b),
    .raddr (raddr),
    .rdata (rd_b)
  );

  assign x0       = backward ? rd_b : rd_a;
  assign out_word = rd_a;

  // coefficient set for this pass
  assign k_c  = highpass ? coef.hp_gain : coef.lp_gain;
  assign f1_c = highpass ? coef.hp_fb1  : coef.lp_fb1;
  assign f2_c = highpass ? coef.hp_fb2  : coef.lp_fb2;

  // multiplier operand select
  always_comb begin
    case (ctrl.coef_sel)
      CS_F1:   mul_a = f1_c;
      CS_F2:   mul_a = f2_c;
      default: mul_a = k_c;
    endcase
    case (ctrl.data_sel)
      DS_X1:   mul_b = x1_r;
      DS_X2:   mul_b = x2_r;
      DS_Y1:   mul_b = y1_r;
      DS_Y2:   mul_b = y2_r;
      default: mul_b = x0;
    endcase
  end

  // shared multiplier, registered product
  assign prod_c = PROD_W'(mul_a) * PROD_W'(mul_b);

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= prod_c;
    end
  end

  // product truncated to q20.44, then accumulated
  assign term  = prod_r >>> TERM_SHIFT;
  assign term2 = term <<< 1;

  always_comb begin
    case (ctrl.acc_op)
      AO_LOAD: acc_nxt = term;
      AO_ADD:  acc_nxt = acc_r + term;
      AO_MID:  acc_nxt = highpass ? acc_r - term2 : acc_r + term2;
      AO_SUB:  acc_nxt = acc_r - term;
      default: acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  // round to q16.16 and saturate
  assign rnd    = (acc_r + ROUND_HALF) >>> ACC_SHIFT;
  assign rnd_hi = rnd[PROD_W-1:DATA_W-1];

  always_comb begin
    if ((&rnd_hi) || !(|rnd_hi)) begin
      y_new = rnd[DATA_W-1:0];
    end else begin
      y_new = rnd[PROD_W-1] ? S32_MIN : S32_MAX;
    end
  end

  // filter history, zero at the start of every pass
  always_ff @(posedge clk) begin
    if (ctrl.hist_clr) begin
      x1_r <= '0;
      x2_r <= '0;
      y1_r <= '0;
      y2_r <= '0;
    end else if (ctrl.commit) begin
      x1_r <= x0;
      x2_r <= x1_r;
      y1_r <= y_new;
      y2_r <= y1_r;
    end
  end

endmodule

/* hdl/zpbp_checker.sv */
module zpbp_checker import zpbp_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input in_item_t  in_data,
  input logic      out_valid,
  input out_item_t out_data
);

  // a flagged item launches the run
  a_launch: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_data.record_end |=> busy)
    else $error("record end did not launch processing");

  // results only appear during a run
  a_out_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe while idle");

  // results stream without gaps up to the last one
  a_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.out_last |=> out_valid)
    else $error("gap in result burst");

  // run ends right after the last result
  a_end: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) && $past(rst_n) |-> $past(out_valid && out_data.out_last))
    else $error("run ended without a last result");

  // nothing follows the last result
  a_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.out_last |=> !out_valid)
    else $error("result after last");

endmodule

bind zero_phase_biquad_bandpass_top zpbp_checker u_zpbp_checker (.*);
